[sv/rde_pkg.sv]
`default_nettype none
package rde_pkg;

    localparam int ROUTE_ENTRIES = 16;
    localparam int SEEN_ENTRIES  = 16;
    localparam int RT_IW = $clog2(ROUTE_ENTRIES);
    localparam int SK_IW = $clog2(SEEN_ENTRIES);
    localparam int SCAN_IW = (RT_IW > SK_IW) ? RT_IW : SK_IW;

    localparam logic [15:0] BCAST_ADDR = 16'hFFFF;
    localparam logic [7:0]  MAX_LQI    = 8'hFF;

    localparam logic [0:0] CFG_MY_ADDRESS    = 1'b0;
    localparam logic [0:0] CFG_TOTAL_DEVICES = 1'b1;

    typedef enum logic [1:0] {
        CMD_RREQ  = 2'd0,
        CMD_RREP  = 2'd1,
        CMD_ORIG  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ACT_NONE     = 3'd0,
        ACT_FWD_RREQ = 3'd1,
        ACT_SEND_REP = 3'd2,
        ACT_FWD_REP  = 3'd3,
        ACT_ORIG_REQ = 3'd4
    } act_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_OWN      = 3'd1,
        ST_DUP      = 3'd2,
        ST_ESTAB    = 3'd3,
        ST_NO_ROUTE = 3'd4
    } stat_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] source_addr;
        logic [15:0] originator;
        logic [15:0] target_addr;
        logic [15:0] request_id;
        logic [7:0]  hop_count;
        logic [7:0]  sender_energy;
        logic [7:0]  link_quality;
        logic [7:0]  own_energy;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] next_addr;
        logic [15:0] out_request_id;
        logic [15:0] out_originator;
        logic [15:0] out_target;
        logic [7:0]  out_hop_count;
        logic [7:0]  out_energy;
        logic [7:0]  out_link_quality;
        logic [2:0]  status;
        logic        route_updated;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEEN_SCAN,
        S_RT1_SCAN,
        S_SC_NEW,
        S_SC_OLD,
        S_SC_CMP,
        S_RT2_SCAN,
        S_DONE,
        S_OUT
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;         // capture input item
        logic scan_clr;     // reset scan index
        logic scan_step;    // advance scan index
        logic seen_scan;    // seen cache scan in progress
        logic rt2_sel;      // route scan looks up the originator
        logic seen_ins;     // insert originator/id into seen cache
        logic rt_ins_new;   // write route at fill pointer
        logic rt_replace;   // overwrite found route
        logic sc_new;       // compute new score
        logic sc_old;       // compute old score and compare
        logic build;        // form result
        logic ctr_inc;      // advance request counter
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic [1:0] command;
        logic       orig_is_me;
        logic       seen_hit;
        logic       rt_hit;
        logic       seen_last;
        logic       rt_last;
        logic       better;
    } dp_stat_t;

    function automatic logic [7:0] sat_inc(input logic [7:0] h);
        return (h == 8'hFF) ? 8'hFF : h + 8'd1;
    endfunction

endpackage
`default_nettype wire

[sv/route_discovery_engine.sv]
// An item may pass through a serial scan of the seen cache and up to two serial
// scans of the route table, one entry per cycle, plus, on a route hit, three
// scoring steps (new score, old score, compare) through one shared unit. One
// item at a time: the next input beat is taken in the cycle after the result beat.
// Reset (aresetn, synchronous, low): tables empty, pointers and counter zero.
`default_nettype none
module route_discovery_engine import rde_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_we,
    input  wire logic [0:0] cfg_idx,
    input  wire logic [15:0] cfg_data,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire in_item_t   s_item,
    output logic            m_valid,
    input  wire logic       m_ready,
    output out_item_t       m_item
);
    dp_cmd_t  cmd;
    dp_stat_t st;

    rde_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .st, .cmd
    );

    rde_dp u_dp (
        .aclk, .aresetn, .cfg_we, .cfg_idx, .cfg_data, .s_item, .cmd,
        .st, .m_item
    );
endmodule
`default_nettype wire

[sv/rde_ctrl.sv]
`default_nettype none
module rde_ctrl import rde_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  wire logic     m_ready,
    input  wire dp_stat_t st,
    output dp_cmd_t       cmd
);

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load     = 1'b1;
                    cmd.scan_clr = 1'b1;
                    state_next   = S_SEEN_SCAN;
                end
            end
            S_SEEN_SCAN: begin
                // first beat after load: dispatch on command
                cmd.seen_scan = 1'b1;
                if (st.command == CMD_RREP) begin
                    cmd.scan_clr = 1'b1;
                    state_next   = S_RT1_SCAN;
                end else if (st.command == CMD_NOP ||
                             (st.command == CMD_RREQ && st.orig_is_me)) begin
                    state_next = S_DONE;
                end else if (st.seen_hit) begin
                    if (st.command == CMD_ORIG) cmd.ctr_inc = 1'b1;
                    state_next = S_DONE;
                end else if (st.seen_last) begin
                    cmd.seen_ins = 1'b1;
                    if (st.command == CMD_ORIG) begin
                        cmd.ctr_inc = 1'b1;
                        state_next  = S_DONE;
                    end else begin
                        cmd.scan_clr = 1'b1;
                        state_next   = S_RT1_SCAN;
                    end
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_RT1_SCAN: begin
                // hold the index on a hit so scoring reads that entry
                if (st.rt_hit) begin
                    state_next = S_SC_NEW;
                end else if (st.rt_last) begin
                    cmd.rt_ins_new = 1'b1;
                    cmd.scan_clr   = 1'b1;
                    state_next     = S_RT2_SCAN;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_SC_NEW: begin
                cmd.sc_new = 1'b1;
                state_next = S_SC_OLD;
            end
            S_SC_OLD: begin
                cmd.sc_old = 1'b1;
                state_next = S_SC_CMP;
            end
            S_SC_CMP: begin
                if (st.better) begin
                    cmd.rt_replace = 1'b1;
                end
                cmd.scan_clr = 1'b1;
                state_next   = S_RT2_SCAN;
            end
            S_RT2_SCAN: begin
                // reply path needs route to originator; request path skips
                cmd.rt2_sel = 1'b1;
                if (st.command != CMD_RREP || st.orig_is_me || st.rt_hit ||
                    st.rt_last) begin
                    state_next = S_DONE;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_DONE: begin
                cmd.build  = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // a result never shows while an item is being taken
    assert property (@(posedge aclk) disable iff (!aresetn) !(s_ready && m_valid))
        else $error("ready and valid together");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.rt_ins_new || cmd.rt_replace) |-> !cmd.seen_ins)
        else $error("route and seen write together");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.build |=> m_valid)
        else $error("result not presented");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result dropped before accept");

endmodule
`default_nettype wire

[sv/rde_dp.sv]
`default_nettype none
module rde_dp import rde_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_idx,
    input  wire logic [15:0] cfg_data,
    input  wire in_item_t    s_item,
    input  wire dp_cmd_t     cmd,
    output dp_stat_t         st,
    output out_item_t        m_item
);

    logic [15:0] my_addr_reg, tot_dev_reg;
    in_item_t    it_reg;

    logic [ROUTE_ENTRIES-1:0] rt_v_reg;
    logic [15:0] rt_dst  [ROUTE_ENTRIES];
    logic [15:0] rt_nh   [ROUTE_ENTRIES];
    logic [7:0]  rt_en   [ROUTE_ENTRIES];
    logic [7:0]  rt_lq   [ROUTE_ENTRIES];
    logic [7:0]  rt_hp   [ROUTE_ENTRIES];
    logic [RT_IW-1:0] rt_fill_reg;

    logic [SEEN_ENTRIES-1:0] sk_v_reg;
    logic [31:0] sk_key [SEEN_ENTRIES];
    logic [SK_IW-1:0] sk_fill_reg;
    logic [15:0] req_ctr_reg;

    logic [SCAN_IW-1:0] idx_reg;    // scan index (shared)
    logic        learned_reg;
    logic        dup_reg;
    logic        fwd_hit_reg;
    logic [15:0] fwd_nh_reg;
    logic [41:0] s_new_reg;
    logic        better_reg;
    out_item_t   out_reg;
    out_item_t   out_next;

    logic [15:0] dnorm;
    logic [15:0] seen_orig;
    logic [15:0] seen_id;
    logic [7:0]  hop_inc;
    logic [15:0] learn_key;
    logic [15:0] rt_key;
    logic [RT_IW-1:0] rt_idx;
    logic [RT_IW-1:0] rt_wr_idx;
    logic [SK_IW-1:0] sk_idx;
    logic        sk_match, rt_match, orig_is_me;

    logic [7:0]  sc_l, sc_e, sc_h;
    logic [18:0] sc_lin;
    logic [15:0] sc_diff;
    logic [31:0] sc_hop;
    logic [41:0] sc_val;

    assign dnorm     = (tot_dev_reg == 16'd0) ? 16'd1 : tot_dev_reg;
    assign hop_inc   = sat_inc(it_reg.hop_count);
    assign seen_orig = (it_reg.command == CMD_ORIG) ? my_addr_reg : it_reg.originator;
    assign seen_id   = (it_reg.command == CMD_ORIG) ? req_ctr_reg : it_reg.request_id;
    assign sk_idx    = idx_reg[SK_IW-1:0];
    assign rt_idx    = idx_reg[RT_IW-1:0];
    assign sk_match  = sk_v_reg[sk_idx] && sk_key[sk_idx] == {seen_orig, seen_id};
    // first route lookup: learned destination; second: originator
    assign learn_key = (it_reg.command == CMD_RREP) ? it_reg.target_addr : it_reg.originator;
    assign rt_key    = cmd.rt2_sel ? it_reg.originator : learn_key;
    assign rt_match  = rt_v_reg[rt_idx] && rt_dst[rt_idx] == rt_key;
    assign rt_wr_idx = cmd.rt_ins_new ? rt_fill_reg : rt_idx;
    assign orig_is_me = (it_reg.originator == my_addr_reg);

    assign st.command    = it_reg.command;
    assign st.orig_is_me = orig_is_me;
    assign st.seen_hit   = sk_match;
    assign st.rt_hit     = rt_match;
    assign st.seen_last  = (idx_reg == SCAN_IW'(SEEN_ENTRIES - 1));
    assign st.rt_last    = (idx_reg == SCAN_IW'(ROUTE_ENTRIES - 1));
    assign st.better     = better_reg;

    // shared scoring unit: new route or the found entry
    always_comb begin
        if (cmd.sc_new) begin
            sc_l = it_reg.link_quality;
            sc_e = it_reg.sender_energy;
            sc_h = hop_inc;
        end else begin
            sc_l = rt_lq[rt_idx];
            sc_e = rt_en[rt_idx];
            sc_h = rt_hp[rt_idx];
        end
        sc_diff = dnorm - {8'd0, sc_h};
        sc_lin  = 19'd500 * {11'd0, sc_l} + 19'd765 * {11'd0, sc_e};
        sc_hop  = ({8'd0, sc_h} < dnorm) ? 32'd51000 * {16'd0, sc_diff} : 32'd0;
        sc_val  = {23'd0, sc_lin} * {26'd0, dnorm} + {10'd0, sc_hop};
    end

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            my_addr_reg <= '0;
            tot_dev_reg <= 16'd1;
        end else if (cfg_we) begin
            case (cfg_idx)
                CFG_MY_ADDRESS:    my_addr_reg <= cfg_data;
                CFG_TOTAL_DEVICES: tot_dev_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // control-side state: pointers, valid bits, scan, item flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rt_v_reg    <= '0;
            sk_v_reg    <= '0;
            rt_fill_reg <= '0;
            sk_fill_reg <= '0;
            req_ctr_reg <= '0;
            idx_reg     <= '0;
            learned_reg <= 1'b0;
            dup_reg     <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end else begin
            if (cmd.scan_clr) begin
                idx_reg <= '0;
            end else if (cmd.scan_step) begin
                idx_reg <= idx_reg + SCAN_IW'(1);
            end
            if (cmd.load) begin
                learned_reg <= 1'b0;
                dup_reg     <= 1'b0;
                fwd_hit_reg <= 1'b0;
            end else begin
                if (cmd.seen_scan && sk_match) dup_reg <= 1'b1;
                if (cmd.rt2_sel && rt_match) fwd_hit_reg <= 1'b1;
                if (cmd.rt_ins_new || cmd.rt_replace) learned_reg <= 1'b1;
            end
            if (cmd.seen_ins) begin
                sk_v_reg[sk_fill_reg] <= 1'b1;
                sk_fill_reg <= (sk_fill_reg == SK_IW'(SEEN_ENTRIES - 1)) ? '0 :
                               sk_fill_reg + SK_IW'(1);
            end
            if (cmd.rt_ins_new) begin
                rt_v_reg[rt_fill_reg] <= 1'b1;
                rt_fill_reg <= (rt_fill_reg == RT_IW'(ROUTE_ENTRIES - 1)) ? '0 :
                               rt_fill_reg + RT_IW'(1);
            end
            if (cmd.ctr_inc) req_ctr_reg <= req_ctr_reg + 16'd1;
        end
    end

    // payload: item, tables, scores, result
    always_ff @(posedge aclk) begin
        if (cmd.load) it_reg <= s_item;
        if (cmd.seen_ins) sk_key[sk_fill_reg] <= {seen_orig, seen_id};
        if (cmd.rt_ins_new || cmd.rt_replace) begin
            rt_dst[rt_wr_idx] <= learn_key;
            rt_nh [rt_wr_idx] <= it_reg.source_addr;
            rt_en [rt_wr_idx] <= it_reg.sender_energy;
            rt_lq [rt_wr_idx] <= it_reg.link_quality;
            rt_hp [rt_wr_idx] <= hop_inc;
        end
        if (cmd.sc_new) s_new_reg <= sc_val;
        if (cmd.sc_old) begin
            better_reg <= ({4'd0, s_new_reg} * 46'd10) > ({4'd0, sc_val} * 46'd11);
        end
        if (cmd.rt2_sel && rt_match) fwd_nh_reg <= rt_nh[rt_idx];
        if (cmd.build) out_reg <= out_next;
    end

    // result build
    always_comb begin
        out_next = '0;
        out_next.route_updated = learned_reg;
        case (cmd_t'(it_reg.command))
            CMD_RREQ: begin
                if (orig_is_me) begin
                    out_next.status = ST_OWN;
                end else if (dup_reg) begin
                    out_next.status = ST_DUP;
                end else begin
                    out_next.out_request_id   = it_reg.request_id;
                    out_next.out_originator   = it_reg.originator;
                    out_next.out_energy       = it_reg.own_energy;
                    out_next.out_link_quality = it_reg.link_quality;
                    if (it_reg.target_addr == my_addr_reg) begin
                        out_next.action     = ACT_SEND_REP;
                        out_next.next_addr  = it_reg.source_addr;
                        out_next.out_target = my_addr_reg;
                    end else begin
                        out_next.action        = ACT_FWD_RREQ;
                        out_next.next_addr     = BCAST_ADDR;
                        out_next.out_target    = it_reg.target_addr;
                        out_next.out_hop_count = hop_inc;
                    end
                end
            end
            CMD_RREP: begin
                if (orig_is_me) begin
                    out_next.status = ST_ESTAB;
                end else if (fwd_hit_reg) begin
                    out_next.action           = ACT_FWD_REP;
                    out_next.next_addr        = fwd_nh_reg;
                    out_next.out_request_id   = it_reg.request_id;
                    out_next.out_originator   = it_reg.originator;
                    out_next.out_target       = it_reg.target_addr;
                    out_next.out_hop_count    = hop_inc;
                    out_next.out_energy       = it_reg.own_energy;
                    out_next.out_link_quality = it_reg.link_quality;
                end else begin
                    out_next.status = ST_NO_ROUTE;
                end
            end
            CMD_ORIG: begin
                out_next.action           = ACT_ORIG_REQ;
                out_next.next_addr        = BCAST_ADDR;
                out_next.out_request_id   = req_ctr_reg - 16'd1;
                out_next.out_originator   = my_addr_reg;
                out_next.out_target       = it_reg.target_addr;
                out_next.out_energy       = it_reg.own_energy;
                out_next.out_link_quality = MAX_LQI;
            end
            default: ;
        endcase
    end
    assign m_item = out_reg;

endmodule
`default_nettype wire
